// ===== sv/text_line_number_visualize_filter_macros.svh =====
// Assertion macros shared by the text display filter modules.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef TEXT_LINE_NUMBER_VISUALIZE_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBER_VISUALIZE_FILTER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define TLNV_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TLNV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TLNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tlnv_pkg.sv =====
// Shared types and constants of the text display filter.
// No dependencies.
package tlnv_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 1;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_ALL       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TABS        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINTING = 3'd5;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QMARK  = 8'd63;
  localparam logic [7:0] CH_CAP_I  = 8'd73;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CTRL_BIAS = 8'd64;

  localparam logic [1:0] BLANK_MAX     = 2'd3;
  localparam logic [1:0] BLANK_SQUEEZE = 2'd2;
  localparam logic [3:0] DIGIT_NINE    = 4'd9;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } tlnv_cfg_t;

  // Classified item: optional line number prefix, then one or two body bytes
  typedef struct packed {
    logic       num_en;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } tlnv_body_t;

endpackage

// ===== sv/tlnv_if.sv =====
// Valid/ready channel interfaces of the text display filter.
// Input channel carries raw bytes, output channel carries display bytes.
interface tlnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_file;

  modport source (output valid, data_byte, first_of_file, input ready);
  modport sink   (input valid, data_byte, first_of_file, output ready);
endinterface

interface tlnv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ===== sv/text_line_number_visualize_filter.sv =====
// Top level of the text display filter (cat-style byte formatter).
// Depends on tlnv_pkg, tlnv_if, tlnv_front, tlnv_queue and tlnv_back.
//
// Usage:
//   in_ch  : raw text bytes (data_byte) with a first_of_file mark; an item is
//            taken at a clock edge with valid and ready both high.
//   out_ch : display bytes (out_byte); last_of_run flags the final byte made
//            from one input item. A squeezed blank line yields no bytes.
//   cfg_*  : write port for the six mode bits; write only while idle.
// The first output byte of an item passes through the two-entry queue, then
// the output register.
// Throughput: one output byte per cycle while out_ch.ready is high, set by
// the single serializer. A plain byte yields one output byte, so plain text
// flows at one item per cycle. A caret escape or a "$" line end yields two
// bytes; a numbered line start adds LINE_DIGITS + 1 bytes (number and TAB).
// Stall: while out_ch.ready is low the output byte holds; the queue absorbs
// up to two items, after which in_ch.ready drops.
// Reset (rst_n low, synchronous): modes clear to 0, previous byte becomes
// newline, blank run 0, line counter 1, queue and output empty.
module text_line_number_visualize_filter #(
  parameter int LINE_DIGITS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tlnv_in_if.sink                            in_ch,
  tlnv_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [tlnv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tlnv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DIGITS_W = 4 * LINE_DIGITS;
  localparam int BODY_W   = $bits(tlnv_pkg::tlnv_body_t);
  localparam int DATA_W   = BODY_W + DIGITS_W;

  tlnv_pkg::tlnv_cfg_t  cfg_r, cfg_nxt;
  tlnv_pkg::tlnv_body_t push_body, head_body;
  logic [DIGITS_W-1:0]  push_digits, head_digits;
  logic [DATA_W-1:0]    push_data, head_data;
  logic                 accept, push, pop, head_valid, q_full;

  // Mode registers: only bit 0 of the write data matters
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tlnv_pkg::CFG_NUMBER_ALL:       cfg_nxt.number_all       = cfg_wdata[0];
        tlnv_pkg::CFG_NUMBER_NONBLANK:  cfg_nxt.number_nonblank  = cfg_wdata[0];
        tlnv_pkg::CFG_SQUEEZE_BLANK:    cfg_nxt.squeeze_blank    = cfg_wdata[0];
        tlnv_pkg::CFG_SHOW_ENDS:        cfg_nxt.show_ends        = cfg_wdata[0];
        tlnv_pkg::CFG_SHOW_TABS:        cfg_nxt.show_tabs        = cfg_wdata[0];
        tlnv_pkg::CFG_SHOW_NONPRINTING: cfg_nxt.show_nonprinting = cfg_wdata[0];
        default:                        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Take a new item whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  tlnv_front #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .data_byte     (in_ch.data_byte),
    .first_of_file (in_ch.first_of_file),
    .push          (push),
    .push_body     (push_body),
    .push_digits   (push_digits)
  );

  assign push_data = {push_body, push_digits};

  tlnv_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (q_full)
  );

  // Split the queue head back into classification and counter snapshot
  assign head_body   = tlnv_pkg::tlnv_body_t'(head_data[DATA_W-1 -: BODY_W]);
  assign head_digits = head_data[DIGITS_W-1:0];

  tlnv_back #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_body   (head_body),
    .head_digits (head_digits),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

// ===== sv/tlnv_front.sv =====
// Front end: accepts raw bytes, keeps line state and the BCD line counter,
// classifies each kept byte into a queue entry. Depends on tlnv_pkg.
module tlnv_front #(
  parameter int LINE_DIGITS = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tlnv_pkg::tlnv_cfg_t        cfg,
  input  logic                       accept,
  input  logic [7:0]                 data_byte,
  input  logic                       first_of_file,
  output logic                       push,
  output tlnv_pkg::tlnv_body_t       push_body,
  output logic [4*LINE_DIGITS-1:0]   push_digits
);

  localparam int CNT_W = 4 * LINE_DIGITS;

  logic [7:0]       prev_r, prev_nxt, prev_eff;
  logic [1:0]       blank_r, blank_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_eff, cnt_adv;
  logic             is_nl, keep, line_start;

  // Saturating BCD increment: a digit steps when all lower digits are nine
  always_comb begin
    logic       low9;
    logic [3:0] dig;
    low9    = 1'b1;
    cnt_adv = cnt_eff;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      dig = cnt_eff[4*i +: 4];
      if (low9) begin
        cnt_adv[4*i +: 4] = (dig == tlnv_pkg::DIGIT_NINE) ? 4'd0 : dig + 4'd1;
      end
      low9 = low9 && (dig == tlnv_pkg::DIGIT_NINE);
    end
    if (low9) begin
      cnt_adv = cnt_eff;
    end
  end

  always_comb begin
    prev_eff = first_of_file ? tlnv_pkg::CH_NL : prev_r;
    cnt_eff  = first_of_file ? CNT_W'(1) : cnt_r;
    is_nl    = (data_byte == tlnv_pkg::CH_NL);

    if ((prev_eff == tlnv_pkg::CH_NL) && is_nl) begin
      blank_nxt = (blank_r == tlnv_pkg::BLANK_MAX) ? blank_r : blank_r + 2'd1;
    end else begin
      blank_nxt = 2'd0;
    end

    keep       = !cfg.squeeze_blank || (blank_nxt < tlnv_pkg::BLANK_SQUEEZE);
    line_start = keep && (prev_eff == tlnv_pkg::CH_NL) &&
                 !(is_nl && cfg.number_nonblank);
    cnt_nxt    = line_start ? cnt_adv : cnt_eff;
    prev_nxt   = data_byte;

    push_body.num_en = line_start && (cfg.number_all || cfg.number_nonblank);
    push_body.two    = 1'b0;
    push_body.b0     = data_byte;
    push_body.b1     = data_byte;
    if (cfg.show_ends && is_nl) begin
      push_body.two = 1'b1;
      push_body.b0  = tlnv_pkg::CH_DOLLAR;
      push_body.b1  = tlnv_pkg::CH_NL;
    end else if (cfg.show_tabs && (data_byte == tlnv_pkg::CH_TAB)) begin
      push_body.two = 1'b1;
      push_body.b0  = tlnv_pkg::CH_CARET;
      push_body.b1  = tlnv_pkg::CH_CAP_I;
    end else if (cfg.show_nonprinting && (data_byte inside {[8'd0:8'd31]}) &&
                 !is_nl && (data_byte != tlnv_pkg::CH_TAB)) begin
      push_body.two = 1'b1;
      push_body.b0  = tlnv_pkg::CH_CARET;
      push_body.b1  = data_byte + tlnv_pkg::CTRL_BIAS;
    end else if (cfg.show_nonprinting && (data_byte == tlnv_pkg::CH_DEL)) begin
      push_body.two = 1'b1;
      push_body.b0  = tlnv_pkg::CH_CARET;
      push_body.b1  = tlnv_pkg::CH_QMARK;
    end

    push_digits = cnt_eff;
    push        = accept && keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= tlnv_pkg::CH_NL;
      blank_r <= 2'd0;
      cnt_r   <= CNT_W'(1);
    end else if (accept) begin
      prev_r  <= prev_nxt;
      blank_r <= blank_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/tlnv_queue.sv =====
// Short queue between front end and serializer.
// Depends on tlnv_pkg and the assertion macro header.
`include "text_line_number_visualize_filter_macros.svh"

module tlnv_queue #(
  parameter int DATA_W = 42
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data,
  output logic              full
);

  localparam int DEPTH = tlnv_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign full       = (count_r == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `TLNV_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `TLNV_ASSERT_IMP(a_pop_nonempty, pop, count_r != '0, "pop from empty queue")
  `TLNV_ASSERT_IMP(a_push_room, push, !full || pop, "push into full queue")

endmodule

// ===== sv/tlnv_back.sv =====
// Back end: walks one queue entry a byte per cycle, while the output is not stalled, into the output register.
// Depends on tlnv_pkg and the assertion macro header.
`include "text_line_number_visualize_filter_macros.svh"

module tlnv_back #(
  parameter int LINE_DIGITS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  tlnv_pkg::tlnv_body_t     head_body,
  input  logic [4*LINE_DIGITS-1:0] head_digits,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_byte,
  output logic                     last_of_run
);

  localparam int POS_W = $clog2(LINE_DIGITS + 3);
  localparam int DIG_W = $clog2(LINE_DIGITS);

  logic [POS_W-1:0] step_r, step_nxt, pos, last_pos;
  logic [DIG_W-1:0] dig_idx;
  logic [3:0]       digit;
  logic             lead_r, lead_nxt, lead_in, lead_now;
  logic             is_last, load, in_digits;
  logic             out_valid_r, out_valid_nxt, last_r;
  logic [7:0]       byte_r, byte_nxt;

  always_comb begin
    pos       = head_body.num_en ? step_r : step_r + POS_W'(LINE_DIGITS + 1);
    last_pos  = head_body.two ? POS_W'(LINE_DIGITS + 2) : POS_W'(LINE_DIGITS + 1);
    is_last   = (pos == last_pos);
    in_digits = (pos < POS_W'(LINE_DIGITS));
    dig_idx   = DIG_W'(POS_W'(LINE_DIGITS - 1) - pos);
    digit     = head_digits[{dig_idx, 2'b00} +: 4];
    lead_in   = (pos == '0) ? 1'b1 : lead_r;
    lead_now  = lead_in && (digit == 4'd0) && (dig_idx != '0);

    if (in_digits) begin
      byte_nxt = lead_now ? tlnv_pkg::CH_SPACE : tlnv_pkg::CH_ZERO + {4'd0, digit};
    end else if (pos == POS_W'(LINE_DIGITS)) begin
      byte_nxt = tlnv_pkg::CH_TAB;
    end else if (pos == POS_W'(LINE_DIGITS + 1)) begin
      byte_nxt = head_body.b0;
    end else begin
      byte_nxt = head_body.b1;
    end

    load = head_valid && (!out_valid_r || out_ready);
    pop  = load && is_last;

    step_nxt = step_r;
    lead_nxt = lead_r;
    if (load) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
      if (in_digits) begin
        lead_nxt = lead_now;
      end
    end
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r <= lead_nxt;
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = byte_r;
  assign last_of_run = last_r;

  `TLNV_ASSERT_ALWAYS(a_step_bound, step_r <= POS_W'(LINE_DIGITS + 2), "step past entry")
  `TLNV_ASSERT_IMP(a_mid_entry_head, step_r != '0, head_valid, "entry vanished mid way")
  `TLNV_ASSERT_NEXT(a_last_rewinds, load && is_last, step_r == '0, "step not rewound")

endmodule
